@@ design/rcem_pkg.sv @@
// Shared constants and register map for the receiver-frame elevon mixer.
package rcem_pkg;

    // Default receiver channel width
    localparam int CHANNEL_BITS_DEF = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_IN_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_IN_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_IN_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_IN_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_IN_MID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_LIMIT  = 3'd7;

    // Register reset values
    localparam logic [10:0] RST_MOTOR_IN_MIN = 11'd60;
    localparam logic [10:0] RST_MOTOR_IN_MAX = 11'd1608;
    localparam logic [10:0] RST_SERVO_IN_MIN = 11'd300;
    localparam logic [10:0] RST_SERVO_IN_MAX = 11'd1900;
    localparam logic [10:0] RST_SERVO_IN_MID = 11'd1100;
    localparam logic [6:0]  RST_MAX_ANGLE    = 7'd75;
    localparam logic [10:0] RST_SERVO_CENTER = 11'd1500;
    localparam logic [9:0]  RST_SERVO_LIMIT  = 10'd500;

    // Flight mode codes
    localparam logic [1:0] MODE_LOCKED    = 2'd0;
    localparam logic [1:0] MODE_NORMAL    = 2'd1;
    localparam logic [1:0] MODE_BALANCING = 2'd2;

    // Switch positions on the mode and takeoff channels
    localparam int MODE_CH_LOCKED    = 1800;
    localparam int MODE_CH_NORMAL    = 1000;
    localparam int MODE_CH_BALANCING = 200;
    localparam int TAKEOFF_CH        = 200;

    // Pulse limits in us and the 50/4.5 scale in Q8
    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;
    localparam logic [11:0] THR_SPAN  = 12'd1000;
    localparam logic [11:0] SCALE_Q8  = 12'd2844;

    // Result beat layout, lowest bit first
    localparam int M_TDATA_W      = 40;
    localparam int OUT_MODE_LO    = 0;
    localparam int OUT_TX_ON      = 2;
    localparam int OUT_TAKEOFF    = 3;
    localparam int OUT_THR_LO     = 4;
    localparam int OUT_THR_UPD    = 15;
    localparam int OUT_LEFT_LO    = 16;
    localparam int OUT_RIGHT_LO   = 27;
    localparam int OUT_SERVO_UPD  = 38;

endpackage

@@ design/rc_elevon_mixer.sv @@
// Receiver-frame to throttle and elevon pulse-width mixer, top level.
//
// Usage:
//   s_ channel: one beat is one receiver frame (roll, pitch, throttle, mode,
//   takeoff channels). s_tready is high only while the block is idle.
//   m_ channel: one beat per frame with mode, flags, throttle and both
//   elevon pulse widths. The result sits in an output register, so a stalled
//   receiver does not block the next frame from being accepted.
//   cfg_ port: writes one of eight registers per cycle; write only when idle.
// Sequence:
//   A frame runs through three passes of one shared multiplier and one
//   radix-2 restoring divider (throttle, roll, pitch), each pass with 21
//   divider steps, then the mix states S_SUM, S_SAT and S_DONE. m_tvalid
//   and s_tready rise together when the result is handed off; the block
//   does not take a new frame before it is through with the last one.
//   If m_tready is low when a result is done, the block waits until the
//   output register frees up.
// Reset:
//   aresetn low clears the mode to locked, the takeoff latch and the output
//   valid flag, and loads all configuration registers with their defaults.
module rc_elevon_mixer #(
    parameter int CHANNEL_BITS = rcem_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // tdata: roll, pitch, throttle, mode, takeoff channels; zero padded
    input  logic [((5*CHANNEL_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // tdata: mode, transmitter_on, takeoff_requested, throttle_us,
    //        throttle_update, left_servo_us, right_servo_us, servo_update
    output logic [rcem_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_wen,
    input  logic [rcem_pkg::CFG_IDX_W-1:0]          cfg_addr,
    input  logic [rcem_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import rcem_pkg::*;

    localparam int CW        = (CHANNEL_BITS > 11) ? CHANNEL_BITS : 11;
    localparam int DIVD_W    = 21;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_SAT  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // Pass selector
    localparam logic [1:0] JOB_THR   = 2'd0;
    localparam logic [1:0] JOB_ROLL  = 2'd1;
    localparam logic [1:0] JOB_PITCH = 2'd2;

    // Configuration registers
    logic [10:0] motor_min_reg, motor_max_reg, servo_min_reg, servo_max_reg;
    logic [10:0] servo_mid_reg, servo_center_reg;
    logic [6:0]  max_angle_reg;
    logic [9:0]  servo_limit_reg;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [1:0]       job_reg, job_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       mode_reg, mode_next;
    logic             takeoff_reg, takeoff_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Datapath registers
    logic [CHANNEL_BITS-1:0] roll_ch_reg, pitch_ch_reg, thr_ch_reg;
    logic                    tx_on_reg, tx_on_next;
    logic [10:0]             mul_a_reg, mul_a_next;
    logic [11:0]             mul_b_reg, mul_b_next;
    logic [10:0]             divisor_reg, divisor_next;
    logic                    bad_reg, bad_next;
    logic                    neg_reg, neg_next;
    logic [DIVD_W-1:0]       quo_reg, quo_next;
    logic [10:0]             rem_reg, rem_next;
    logic [10:0]             thr_us_reg, thr_us_next;
    logic signed [31:0]      roll_q8_reg, roll_q8_next, pitch_q8_reg, pitch_q8_next;
    logic signed [32:0]      lmix_reg, lmix_next, rmix_reg, rmix_next;
    logic signed [20:0]      lt_reg, lt_next, rt_reg, rt_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Input beat unpack
    logic [CHANNEL_BITS-1:0] in_roll, in_pitch, in_thr, in_mode, in_take;
    assign in_roll  = s_tdata[0*CHANNEL_BITS +: CHANNEL_BITS];
    assign in_pitch = s_tdata[1*CHANNEL_BITS +: CHANNEL_BITS];
    assign in_thr   = s_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign in_mode  = s_tdata[3*CHANNEL_BITS +: CHANNEL_BITS];
    assign in_take  = s_tdata[4*CHANNEL_BITS +: CHANNEL_BITS];

    logic s_accept;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Operand prep: clamp the selected channel into its configured range and take its offset from the servo midpoint
    logic [CHANNEL_BITS-1:0] sel_ch;
    logic [10:0]             lo, hi;
    logic [CW-1:0]           ch_w, lo_w, hi_w, clamp_w;
    logic [10:0]             v11;
    logic signed [11:0]      dev;
    logic [11:0]             dev_mag;

    always_comb begin
        if (job_reg == JOB_THR) begin
            sel_ch = thr_ch_reg;
            lo     = motor_min_reg;
            hi     = motor_max_reg;
        end else begin
            sel_ch = (job_reg == JOB_ROLL) ? roll_ch_reg : pitch_ch_reg;
            lo     = servo_min_reg;
            hi     = servo_max_reg;
        end
        ch_w = CW'(sel_ch);
        lo_w = CW'(lo);
        hi_w = CW'(hi);
        if (ch_w < lo_w)       clamp_w = lo_w;
        else if (ch_w > hi_w)  clamp_w = hi_w;
        else                   clamp_w = ch_w;
        v11     = clamp_w[10:0];
        dev     = $signed({1'b0, v11}) - $signed({1'b0, servo_mid_reg});
        dev_mag = dev[11] ? 12'(-dev) : 12'(dev);
    end

    // Shared multiplier: stick/throttle scaling, then the Q8 angle scale
    logic [18:0] mul_x;
    logic [11:0] mul_y;
    logic [30:0] mul_p;

    always_comb begin
        if (state_reg == S_POST) begin
            mul_x = bad_reg ? 19'd0 : quo_reg[18:0];
            mul_y = SCALE_Q8;
        end else begin
            mul_x = 19'(mul_a_reg);
            mul_y = mul_b_reg;
        end
    end
    assign mul_p = 31'(mul_x) * 31'(mul_y);

    // Shared restoring divider step
    logic [11:0] div_shift;
    logic        div_ge;
    assign div_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});

    // Servo finish: floor the Q8 pulse and clamp to the pulse window
    logic signed [12:0] l_us, r_us;
    logic [10:0]        l_cl, r_cl, center_cl;
    assign l_us = 13'(lt_reg >>> 8);
    assign r_us = 13'(rt_reg >>> 8);

    always_comb begin
        if (l_us < $signed({2'b00, PULSE_MIN}))      l_cl = PULSE_MIN;
        else if (l_us > $signed({2'b00, PULSE_MAX})) l_cl = PULSE_MAX;
        else                                         l_cl = l_us[10:0];
        if (r_us < $signed({2'b00, PULSE_MIN}))      r_cl = PULSE_MIN;
        else if (r_us > $signed({2'b00, PULSE_MAX})) r_cl = PULSE_MAX;
        else                                         r_cl = r_us[10:0];
        if (servo_center_reg < PULSE_MIN)            center_cl = PULSE_MIN;
        else if (servo_center_reg > PULSE_MAX)       center_cl = PULSE_MAX;
        else                                         center_cl = servo_center_reg;
    end

    // Mix saturation limit in Q8
    logic signed [32:0] lim_pos, lim_neg;
    assign lim_pos = $signed({15'd0, servo_limit_reg, 8'd0});
    assign lim_neg = -lim_pos;

    // Sequencer and datapath next state
    always_comb begin
        logic [10:0]        res_thr;
        logic [10:0]        res_l, res_r;
        logic               res_supd;
        logic signed [32:0] lsat, rsat;
        logic signed [31:0] ang;

        state_next    = state_reg;
        job_next      = job_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        takeoff_next  = takeoff_reg;
        tx_on_next    = tx_on_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        divisor_next  = divisor_reg;
        bad_next      = bad_reg;
        neg_next      = neg_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        thr_us_next   = thr_us_reg;
        roll_q8_next  = roll_q8_reg;
        pitch_q8_next = pitch_q8_reg;
        lmix_next     = lmix_reg;
        rmix_next     = rmix_reg;
        lt_next       = lt_reg;
        rt_next       = rt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        res_thr       = PULSE_MIN;
        res_l         = center_cl;
        res_r         = center_cl;
        res_supd      = 1'b1;
        lsat          = lmix_reg;
        rsat          = rmix_reg;
        ang           = $signed({1'b0, mul_p});

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    // Mode switch and takeoff latch update on the frame itself
                    if (CW'(in_mode) == CW'(MODE_CH_LOCKED))         mode_next = MODE_LOCKED;
                    else if (CW'(in_mode) == CW'(MODE_CH_NORMAL))    mode_next = MODE_NORMAL;
                    else if (CW'(in_mode) == CW'(MODE_CH_BALANCING)) mode_next = MODE_BALANCING;
                    if (CW'(in_take) == CW'(TAKEOFF_CH)) takeoff_next = 1'b1;
                    tx_on_next = (in_mode != '0);
                    job_next   = JOB_THR;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                bad_next     = (hi <= lo);
                divisor_next = hi - lo;
                if (job_reg == JOB_THR) begin
                    mul_a_next = v11 - lo;
                    mul_b_next = THR_SPAN;
                    neg_next   = 1'b0;
                end else begin
                    mul_a_next = dev_mag[10:0];
                    mul_b_next = {4'd0, max_angle_reg, 1'b0};
                    neg_next   = (job_reg == JOB_ROLL) ? !dev[11] : dev[11];
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                quo_next   = mul_p[DIVD_W-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = div_ge ? 11'(div_shift - {1'b0, divisor_reg}) : div_shift[10:0];
                quo_next = {quo_reg[DIVD_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_POST;
            end
            S_POST: begin
                if (job_reg == JOB_THR) begin
                    thr_us_next = bad_reg ? PULSE_MIN : PULSE_MIN + {1'b0, quo_reg[9:0]};
                    job_next    = JOB_ROLL;
                    state_next  = S_PREP;
                end else begin
                    if (neg_reg) ang = -ang;
                    if (job_reg == JOB_ROLL) begin
                        roll_q8_next = ang;
                        job_next     = JOB_PITCH;
                        state_next   = S_PREP;
                    end else begin
                        pitch_q8_next = ang;
                        state_next    = S_SUM;
                    end
                end
            end
            S_SUM: begin
                lmix_next  = 33'(roll_q8_reg) - 33'(pitch_q8_reg);
                rmix_next  = 33'(roll_q8_reg) + 33'(pitch_q8_reg);
                state_next = S_SAT;
            end
            S_SAT: begin
                if (lmix_reg > lim_pos)      lsat = lim_pos;
                else if (lmix_reg < lim_neg) lsat = lim_neg;
                if (rmix_reg > lim_pos)      rsat = lim_pos;
                else if (rmix_reg < lim_neg) rsat = lim_neg;
                lt_next    = $signed({2'b00, servo_center_reg, 8'd0}) + 21'(lsat);
                rt_next    = $signed({2'b00, servo_center_reg, 8'd0}) + 21'(rsat);
                state_next = S_DONE;
            end
            S_DONE: begin
                case (mode_reg)
                    MODE_NORMAL: begin
                        res_thr  = thr_us_reg;
                        res_l    = l_cl;
                        res_r    = r_cl;
                        res_supd = tx_on_reg;
                    end
                    MODE_BALANCING: begin
                        res_thr  = thr_us_reg;
                        res_supd = 1'b0;
                    end
                    default: begin
                        res_thr  = PULSE_MIN;
                        res_supd = 1'b1;
                    end
                endcase
                // Hand off only when the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {1'b0, res_supd, res_r, res_l, 1'b1, res_thr,
                                     takeoff_reg, tx_on_reg, mode_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            job_reg      <= JOB_THR;
            cnt_reg      <= '0;
            mode_reg     <= MODE_LOCKED;
            takeoff_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            cnt_reg      <= cnt_next;
            mode_reg     <= mode_next;
            takeoff_reg  <= takeoff_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_min_reg    <= RST_MOTOR_IN_MIN;
            motor_max_reg    <= RST_MOTOR_IN_MAX;
            servo_min_reg    <= RST_SERVO_IN_MIN;
            servo_max_reg    <= RST_SERVO_IN_MAX;
            servo_mid_reg    <= RST_SERVO_IN_MID;
            max_angle_reg    <= RST_MAX_ANGLE;
            servo_center_reg <= RST_SERVO_CENTER;
            servo_limit_reg  <= RST_SERVO_LIMIT;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_MOTOR_IN_MIN: motor_min_reg    <= cfg_wdata;
                CFG_MOTOR_IN_MAX: motor_max_reg    <= cfg_wdata;
                CFG_SERVO_IN_MIN: servo_min_reg    <= cfg_wdata;
                CFG_SERVO_IN_MAX: servo_max_reg    <= cfg_wdata;
                CFG_SERVO_IN_MID: servo_mid_reg    <= cfg_wdata;
                CFG_MAX_ANGLE:    max_angle_reg    <= cfg_wdata[6:0];
                CFG_SERVO_CENTER: servo_center_reg <= cfg_wdata;
                CFG_SERVO_LIMIT:  servo_limit_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            roll_ch_reg  <= in_roll;
            pitch_ch_reg <= in_pitch;
            thr_ch_reg   <= in_thr;
        end
        tx_on_reg    <= tx_on_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        divisor_reg  <= divisor_next;
        bad_reg      <= bad_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        thr_us_reg   <= thr_us_next;
        roll_q8_reg  <= roll_q8_next;
        pitch_q8_reg <= pitch_q8_next;
        lmix_reg     <= lmix_next;
        rmix_reg     <= rmix_next;
        lt_reg       <= lt_next;
        rt_reg       <= rt_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

@@ design/rcem_checker.sv @@
// Port-level checks for the elevon mixer, bound to its top level.
module rcem_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rcem_pkg::M_TDATA_W-1:0] m_tdata
);
    import rcem_pkg::*;

    logic [1:0]  f_mode;
    logic [10:0] f_thr, f_left, f_right;
    assign f_mode  = m_tdata[OUT_MODE_LO +: 2];
    assign f_thr   = m_tdata[OUT_THR_LO +: 11];
    assign f_left  = m_tdata[OUT_LEFT_LO +: 11];
    assign f_right = m_tdata[OUT_RIGHT_LO +: 11];

    // Reset empties the output and leaves the block ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    // A frame in work blocks the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accepting a frame");

    // A stalled result beat holds until taken
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Every result beat sets throttle_update and carries pulses inside the pulse window
    a_pulse_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_THR_UPD] &&
                     f_thr   >= PULSE_MIN && f_thr   <= PULSE_MAX &&
                     f_left  >= PULSE_MIN && f_left  <= PULSE_MAX &&
                     f_right >= PULSE_MIN && f_right <= PULSE_MAX)
        else $error("pulse width out of window");

    // Locked mode idles the motor and drives the servos
    a_locked_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && f_mode == MODE_LOCKED |->
            f_thr == PULSE_MIN && m_tdata[OUT_SERVO_UPD] && f_left == f_right)
        else $error("locked mode result wrong");

endmodule

bind rc_elevon_mixer rcem_checker u_rcem_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the receiver-frame elevon mixer.
module tb;
    import rcem_pkg::*;

    localparam int CH_W = CHANNEL_BITS_DEF;
    localparam int S_W  = ((5*CH_W+7)/8)*8;

    // One receiver frame, roll in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] takeoff;
        logic [CH_W-1:0] mode;
        logic [CH_W-1:0] thr;
        logic [CH_W-1:0] pitch;
        logic [CH_W-1:0] roll;
    } frame_t;

    // One result beat, mode in the lowest bits
    typedef struct packed {
        logic        pad;
        logic        servo_upd;
        logic [10:0] right;
        logic [10:0] left;
        logic        thr_upd;
        logic [10:0] thr;
        logic        take;
        logic        tx;
        logic [1:0]  mode;
    } mix_t;

    // Hand-typed expectation attached to a frame, or none
    typedef struct {
        bit   typed;
        mix_t r;
    } frame_tag_t;

    typedef struct {
        frame_t f;
        bit     typed;
        mix_t   r;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_W-1:0]       s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rc_elevon_mixer #(.CHANNEL_BITS(CH_W)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Predictor copy of the registers and state
    int         cf_mot_min = int'(RST_MOTOR_IN_MIN);
    int         cf_mot_max = int'(RST_MOTOR_IN_MAX);
    int         cf_srv_min = int'(RST_SERVO_IN_MIN);
    int         cf_srv_max = int'(RST_SERVO_IN_MAX);
    int         cf_srv_mid = int'(RST_SERVO_IN_MID);
    int         cf_angle   = int'(RST_MAX_ANGLE);
    int         cf_center  = int'(RST_SERVO_CENTER);
    int         cf_limit   = int'(RST_SERVO_LIMIT);
    logic [1:0] mode_st = MODE_LOCKED;
    logic       takeoff_st = 1'b0;

    mix_t       pending_pulses[$];
    frame_tag_t frame_tags[$];
    int         mix_errors = 0;
    int         results_seen = 0;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;
    int         rx_stall = 0;

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Throttle channel to pulse width
    function automatic int throttle_pulse(logic [CH_W-1:0] ch);
        longint v;
        if (cf_mot_max <= cf_mot_min) return int'(PULSE_MIN);
        v = clampl(longint'(ch), cf_mot_min, cf_mot_max);
        return int'(PULSE_MIN) + int'((v - cf_mot_min) * 1000 / (cf_mot_max - cf_mot_min));
    endfunction

    // Stick channel to whole degrees, truncated toward zero
    function automatic longint stick_deg(logic [CH_W-1:0] ch, bit neg);
        longint v, prod;
        if (cf_srv_max <= cf_srv_min) return 0;
        v = clampl(longint'(ch), cf_srv_min, cf_srv_max);
        prod = (v - cf_srv_mid) * (2 * longint'(cf_angle));
        if (neg) prod = -prod;
        return prod / longint'(cf_srv_max - cf_srv_min);
    endfunction

    // Q8 deflection to elevon pulse width
    function automatic int elevon_pulse(longint mix_q8);
        longint lim, t;
        lim = longint'(cf_limit) * 256;
        t = longint'(cf_center) * 256 + clampl(mix_q8, -lim, lim);
        return int'(clampl(t >>> 8, PULSE_MIN, PULSE_MAX));
    endfunction

    // Advances the mode state by one frame and returns its result beat
    function automatic mix_t predict_mix(frame_t f);
        mix_t   r;
        longint ra, pa;
        int     ctr;
        ctr = int'(clampl(cf_center, PULSE_MIN, PULSE_MAX));
        if (f.mode == MODE_CH_LOCKED) mode_st = MODE_LOCKED;
        else if (f.mode == MODE_CH_NORMAL) mode_st = MODE_NORMAL;
        else if (f.mode == MODE_CH_BALANCING) mode_st = MODE_BALANCING;
        if (f.takeoff == TAKEOFF_CH) takeoff_st = 1'b1;
        r = '0;
        r.mode = mode_st;
        r.tx = (f.mode != 0);
        r.take = takeoff_st;
        r.thr_upd = 1'b1;
        if (mode_st == MODE_NORMAL) begin
            ra = stick_deg(f.roll, 1'b1) * longint'(SCALE_Q8);
            pa = stick_deg(f.pitch, 1'b0) * longint'(SCALE_Q8);
            r.thr = 11'(throttle_pulse(f.thr));
            r.left = 11'(elevon_pulse(ra - pa));
            r.right = 11'(elevon_pulse(ra + pa));
            r.servo_upd = r.tx;
        end else if (mode_st == MODE_BALANCING) begin
            r.thr = 11'(throttle_pulse(f.thr));
            r.left = 11'(ctr);
            r.right = 11'(ctr);
            r.servo_upd = 1'b0;
        end else begin
            r.thr = PULSE_MIN;
            r.left = 11'(ctr);
            r.right = 11'(ctr);
            r.servo_upd = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
        mix_errors++;
    endtask

    // Observe config writes, check result beats, predict on accepted frames
    always @(posedge aclk) begin : monitor
        mix_t       got;
        mix_t       want;
        frame_tag_t tag;
        mix_t       pred;
        if (!aresetn) begin
            mode_st = MODE_LOCKED;
            takeoff_st = 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    CFG_MOTOR_IN_MIN: cf_mot_min = int'(cfg_wdata);
                    CFG_MOTOR_IN_MAX: cf_mot_max = int'(cfg_wdata);
                    CFG_SERVO_IN_MIN: cf_srv_min = int'(cfg_wdata);
                    CFG_SERVO_IN_MAX: cf_srv_max = int'(cfg_wdata);
                    CFG_SERVO_IN_MID: cf_srv_mid = int'(cfg_wdata);
                    CFG_MAX_ANGLE:    cf_angle   = int'(cfg_wdata[6:0]);
                    CFG_SERVO_CENTER: cf_center  = int'(cfg_wdata);
                    CFG_SERVO_LIMIT:  cf_limit   = int'(cfg_wdata[9:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = mix_t'(m_tdata);
                if (pending_pulses.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = pending_pulses.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode", got.mode, want.mode);
                    if (got.tx !== want.tx)
                        report_mismatch("transmitter_on", got.tx, want.tx);
                    if (got.take !== want.take)
                        report_mismatch("takeoff_requested", got.take, want.take);
                    if (got.thr !== want.thr)
                        report_mismatch("throttle_us", got.thr, want.thr);
                    if (got.thr_upd !== want.thr_upd)
                        report_mismatch("throttle_update", got.thr_upd, want.thr_upd);
                    if (got.left !== want.left)
                        report_mismatch("left_servo_us", got.left, want.left);
                    if (got.right !== want.right)
                        report_mismatch("right_servo_us", got.right, want.right);
                    if (got.servo_upd !== want.servo_upd)
                        report_mismatch("servo_update", got.servo_upd, want.servo_upd);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                pred = predict_mix(frame_t'(s_tdata[$bits(frame_t)-1:0]));
                if (frame_tags.size() != 0) tag = frame_tags.pop_front();
                else tag.typed = 1'b0;
                pending_pulses.push_back(tag.typed ? tag.r : pred);
            end
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 20);
        return $urandom_range(21, 200);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 30) rx_stall = pick_gap();
        end
        if ($urandom_range(0, 999) == 0) rx_steady = !rx_steady;
    end

    function automatic frame_t mkf(int roll, int pitch, int thr, int mode, int take);
        frame_t f;
        f.roll = CH_W'(roll);
        f.pitch = CH_W'(pitch);
        f.thr = CH_W'(thr);
        f.mode = CH_W'(mode);
        f.takeoff = CH_W'(take);
        return f;
    endfunction

    function automatic mix_t mkr(logic [1:0] mode, bit tx, bit take, int thr,
                                 int left, int right, bit supd);
        mix_t r;
        r = '0;
        r.mode = mode;
        r.tx = tx;
        r.take = take;
        r.thr = 11'(thr);
        r.thr_upd = 1'b1;
        r.left = 11'(left);
        r.right = 11'(right);
        r.servo_upd = supd;
        return r;
    endfunction

    // Offer one frame, waiting out the optional gap first
    task automatic send_frame(frame_t f, bit typed, mix_t r);
        frame_tag_t     tag;
        int             gap;
        logic [S_W-1:0] word;
        if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
        gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        tag.typed = typed;
        tag.r = r;
        frame_tags.push_back(tag);
        word = '0;
        word[$bits(frame_t)-1:0] = f;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every pending result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pulses.size() != 0 || frame_tags.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_addr <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        cfg_wen <= 1'b1;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(int mmin, int mmax, int smin, int smax, int smid,
                              int ang, int ctr, int lim);
        write_reg(CFG_MOTOR_IN_MIN, mmin);
        write_reg(CFG_MOTOR_IN_MAX, mmax);
        write_reg(CFG_SERVO_IN_MIN, smin);
        write_reg(CFG_SERVO_IN_MAX, smax);
        write_reg(CFG_SERVO_IN_MID, smid);
        write_reg(CFG_MAX_ANGLE, ang);
        write_reg(CFG_SERVO_CENTER, ctr);
        write_reg(CFG_SERVO_LIMIT, lim);
    endtask

    // Channel value mostly around the given accepted range
    function automatic int pick_chan(int lo, int hi, int mid);
        int p;
        p = $urandom_range(0, 99);
        if (p < 70 && lo < hi)
            return $urandom_range((lo > 20) ? lo - 20 : 0, (hi < 2027) ? hi + 20 : 2047);
        if (p < 80)
            return $urandom_range((mid > 10) ? mid - 10 : 0, (mid < 2037) ? mid + 10 : 2047);
        return $urandom_range(0, 2047);
    endfunction

    task automatic run_random(int n);
        frame_t f;
        int     p;
        mix_t   none;
        none = '0;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 30) f.mode = CH_W'(MODE_CH_NORMAL);
            else if (p < 40) f.mode = CH_W'(MODE_CH_LOCKED);
            else if (p < 50) f.mode = CH_W'(MODE_CH_BALANCING);
            else if (p < 58) f.mode = '0;
            else f.mode = CH_W'($urandom_range(0, 2047));
            f.takeoff = ($urandom_range(0, 99) < 3) ? CH_W'(TAKEOFF_CH)
                                                     : CH_W'($urandom_range(0, 2047));
            f.roll = CH_W'(pick_chan(cf_srv_min, cf_srv_max, cf_srv_mid));
            f.pitch = CH_W'(pick_chan(cf_srv_min, cf_srv_max, cf_srv_mid));
            f.thr = CH_W'(pick_chan(cf_mot_min, cf_mot_max, (cf_mot_min + cf_mot_max) / 2));
            send_frame(f, 1'b0, none);
        end
    endtask

    // Stimulus
    initial begin : stimulus
        dir_row_t dir_tab[$];
        int       a, b, c, d;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at the reset configuration
        dir_tab.push_back('{mkf(0, 0, 0, 0, 0), 1'b1,
                           mkr(MODE_LOCKED, 0, 0, 1000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(2047, 2047, 2047, 1800, 2047), 1'b1,
                           mkr(MODE_LOCKED, 1, 0, 1000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(1100, 1100, 60, 1000, 0), 1'b1,
                           mkr(MODE_NORMAL, 1, 0, 1000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(1100, 1100, 1608, 1000, 0), 1'b1,
                           mkr(MODE_NORMAL, 1, 0, 2000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(0, 0, 2047, 1000, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(2047, 2047, 0, 1000, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(2047, 0, 834, 1000, 1), 1'b0, '0});
        dir_tab.push_back('{mkf(0, 2047, 1200, 1000, 199), 1'b0, '0});
        // transmitter off keeps the mode and stops the servo drive
        dir_tab.push_back('{mkf(1500, 700, 1000, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(800, 1400, 400, 1234, 201), 1'b0, '0});
        // takeoff request latches
        dir_tab.push_back('{mkf(1100, 1100, 1608, 1799, 200), 1'b1,
                           mkr(MODE_NORMAL, 1, 1, 2000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(300, 1900, 1608, 200, 0), 1'b1,
                           mkr(MODE_BALANCING, 1, 1, 2000, 1500, 1500, 0)});
        dir_tab.push_back('{mkf(1024, 1024, 0, 1801, 0), 1'b1,
                           mkr(MODE_BALANCING, 1, 1, 1000, 1500, 1500, 0)});
        dir_tab.push_back('{mkf(1024, 1024, 60, 0, 0), 1'b1,
                           mkr(MODE_BALANCING, 0, 1, 1000, 1500, 1500, 0)});
        dir_tab.push_back('{mkf(0, 0, 1000, 199, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(0, 0, 0, 1001, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(0, 0, 0, 999, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(2047, 2047, 2047, 1800, 0), 1'b1,
                           mkr(MODE_LOCKED, 1, 1, 1000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(1234, 567, 890, 201, 0), 1'b1,
                           mkr(MODE_LOCKED, 1, 1, 1000, 1500, 1500, 1)});
        dir_tab.push_back('{mkf(1300, 900, 700, 1000, 0), 1'b0, '0});
        dir_tab.push_back('{mkf(2047, 2047, 2047, 2047, 2047), 1'b0, '0});
        dir_tab.push_back('{mkf(1101, 1099, 61, 1000, 0), 1'b0, '0});
        foreach (dir_tab[i]) send_frame(dir_tab[i].f, dir_tab[i].typed, dir_tab[i].r);

        // Random frames at the reset configuration, then over a run of settings, extremes first
        run_random(128);
        drain_results();
        set_config(0, 2047, 0, 2047, 0, 90, 1000, 1000);
        run_random(128);
        drain_results();
        // both input ranges empty
        set_config(2047, 0, 2047, 2047, 2047, 0, 2000, 0);
        run_random(128);
        drain_results();
        set_config(100, 1900, 200, 1800, 2047, 90, 2000, 1000);
        run_random(128);
        drain_results();
        set_config(500, 500, 0, 2047, 1024, 1, 1000, 300);
        run_random(128);
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            a = $urandom_range(0, 2047);
            b = $urandom_range(0, 2047);
            c = $urandom_range(0, 2047);
            d = $urandom_range(0, 2047);
            if ($urandom_range(0, 9) != 0) begin
                if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
                if (c > d) begin c = c ^ d; d = c ^ d; c = c ^ d; end
            end
            set_config(a, b, c, d,
                       (c < d) ? $urandom_range(c, d) : $urandom_range(0, 2047),
                       $urandom_range(0, 90), $urandom_range(1000, 2000),
                       $urandom_range(0, 1000));
            run_random(128);
        end

        s_tvalid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mix_errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("timeout with %0d results pending", pending_pulses.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
